FILE: rtl/ffsa_pkg.sv
`default_nettype none
package ffsa_pkg;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NO_SPACE  = 2'd1;
    localparam logic [1:0] STS_ZERO      = 2'd2;
    localparam logic [1:0] STS_BAD_RANGE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic load;    // latch request, restart scan
        logic scan;    // examine one slot
        logic commit;  // update marks, write result register
    } t_cmd;

    typedef struct packed {
        logic is_zero;
        logic is_alloc;
        logic too_big;
        logic hit;
        logic scan_end;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/ffsa_ctrl.sv
`default_nettype none
module ffsa_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  ffsa_pkg::t_sts     i_sts,
    output ffsa_pkg::t_cmd     o_cmd
);

    ffsa_pkg::t_state r_state;
    ffsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffsa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            ffsa_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ffsa_pkg::ST_EVAL;
                end
            end
            ffsa_pkg::ST_EVAL: begin
                if (i_sts.is_alloc && !i_sts.is_zero && !i_sts.too_big) begin
                    n_state = ffsa_pkg::ST_SCAN;
                end else begin
                    n_state = ffsa_pkg::ST_PUT;
                end
            end
            ffsa_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit || i_sts.scan_end) begin
                    n_state = ffsa_pkg::ST_PUT;
                end
            end
            ffsa_pkg::ST_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ffsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ffsa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/ffsa_dp.sv
`default_nettype none
module ffsa_dp #(
    parameter int POOL_SLOTS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  ffsa_pkg::t_cmd     i_cmd,
    output ffsa_pkg::t_sts     o_sts,
    input  wire [15:0]         i_s_axis_tdata,
    input  wire                i_s_axis_tuser,
    output logic               o_m_axis_tvalid,
    input  wire                i_m_axis_tready,
    output logic [7:0]         o_m_axis_tdata,
    output logic [1:0]         o_m_axis_tuser
);

    localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW = ((IW > 5) ? IW : 5) + 1;

    logic [POOL_SLOTS-1:0] r_busy;
    logic                  r_func;
    logic [4:0]            r_cnt;
    logic [3:0]            r_req_start;
    logic [IW-1:0]         r_idx;
    logic [4:0]            r_run;
    logic                  r_hit;
    logic [CW-1:0]         r_start;
    logic                  r_o_valid;
    logic [1:0]            r_o_status;
    logic [3:0]            r_o_grant;

    logic                  slot_free;
    logic                  hit;
    logic                  scan_end;
    logic                  is_zero;
    logic                  too_big;
    logic                  bad_range;
    logic [CW-1:0]         cnt_w;
    logic [CW-1:0]         req_start_w;
    logic [CW-1:0]         mark_lo;
    logic [CW-1:0]         mark_hi;
    logic [POOL_SLOTS-1:0] mark_mask;
    logic [1:0]            res_status;
    logic                  out_free;

    assign cnt_w       = CW'(r_cnt);
    assign req_start_w = CW'(r_req_start);
    assign is_zero     = (r_cnt == 5'd0);
    assign too_big     = (cnt_w > CW'(POOL_SLOTS));
    assign bad_range   = (req_start_w >= CW'(POOL_SLOTS))
                      || ((req_start_w + cnt_w) > CW'(POOL_SLOTS));

    // running length of free slots ending at the scanned slot
    assign slot_free = !r_busy[r_idx];
    assign hit       = slot_free && (({1'b0, r_run} + 6'd1) == {1'b0, r_cnt});
    assign scan_end  = (r_idx == IW'(POOL_SLOTS - 1));

    assign mark_lo = (r_func == ffsa_pkg::FUNC_ALLOC) ? r_start : req_start_w;
    assign mark_hi = mark_lo + cnt_w;

    always_comb begin
        for (int j = 0; j < POOL_SLOTS; j++) begin
            mark_mask[j] = (CW'(j) >= mark_lo) && (CW'(j) < mark_hi);
        end
    end

    always_comb begin
        if (is_zero) begin
            res_status = ffsa_pkg::STS_ZERO;
        end else if (r_func == ffsa_pkg::FUNC_FREE) begin
            res_status = bad_range ? ffsa_pkg::STS_BAD_RANGE : ffsa_pkg::STS_OK;
        end else begin
            res_status = r_hit ? ffsa_pkg::STS_OK : ffsa_pkg::STS_NO_SPACE;
        end
    end

    assign out_free = !r_o_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= i_s_axis_tuser;
            r_cnt       <= i_s_axis_tdata[4:0];
            r_req_start <= i_s_axis_tdata[8:5];
        end
        if (i_cmd.scan && hit) begin
            r_start <= CW'(r_idx) - cnt_w + CW'(1);
        end
        if (i_cmd.commit) begin
            r_o_status <= res_status;
            r_o_grant  <= (res_status == ffsa_pkg::STS_OK && r_func == ffsa_pkg::FUNC_ALLOC)
                          ? r_start[3:0] : 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_idx     <= '0;
            r_run     <= '0;
            r_hit     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
                r_run <= '0;
                r_hit <= 1'b0;
            end else if (i_cmd.scan) begin
                r_run <= slot_free ? (r_run + 5'd1) : 5'd0;
                if (hit) begin
                    r_hit <= 1'b1;
                end
                if (!scan_end) begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            if (i_cmd.commit) begin
                if (res_status == ffsa_pkg::STS_OK) begin
                    if (r_func == ffsa_pkg::FUNC_ALLOC) begin
                        r_busy <= r_busy | mark_mask;
                    end else begin
                        r_busy <= r_busy & ~mark_mask;
                    end
                end
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.is_zero  = is_zero;
        o_sts.is_alloc = (r_func == ffsa_pkg::FUNC_ALLOC);
        o_sts.too_big  = too_big;
        o_sts.hit      = hit;
        o_sts.scan_end = scan_end;
        o_sts.out_free = out_free;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {4'd0, r_o_grant};
    assign o_m_axis_tuser  = r_o_status;

endmodule
`default_nettype wire

FILE: rtl/first_fit_slot_allocator.sv
// First-fit slot allocator over a pool of POOL_SLOTS busy marks. Each request
// (allocate or free) gives one result. A free, a zero-count request or an
// allocate larger than the pool goes from the evaluate state straight to the
// put state, which writes the result register. An allocate walks the bitmap
// one slot per cycle, keeping the length of the current free run. It stops at
// the first slot that completes a run of the requested length, and then goes
// to the put state. When no run is found the walk covers the whole pool.
// One request is in flight at a time. The next is taken the cycle after the
// previous result is loaded into the output register. That register holds the
// result until the sink takes it, and while it is still full the next result
// waits. Marks are flip-flops cleared by reset.
`default_nettype none
module first_fit_slot_allocator #(
    parameter int POOL_SLOTS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [15:0]  i_s_axis_tdata,   // [4:0] slot_count, [8:5] start_slot, rest 0
    input  wire         i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [3:0] granted_slot, rest 0
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    ffsa_pkg::t_cmd cmd;
    ffsa_pkg::t_sts sts;

    ffsa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    ffsa_dp #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

FILE: rtl/ffsa_checker.sv
`default_nettype none
module ffsa_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_axis_tvalid,
    input wire        o_s_axis_tready,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [7:0]  o_m_axis_tdata,
    input wire [1:0]  o_m_axis_tuser
);

    // one request at a time: acceptance closes the input side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while another is in flight");

    // grant is zero on any request whose status is not OK
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ffsa_pkg::STS_OK) |-> (o_m_axis_tdata == 8'd0))
        else $error("nonzero grant on failed request");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            ($stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind first_fit_slot_allocator ffsa_checker u_ffsa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire
